// ----- rtl/core/ds2i_pkg.sv -----
// Shared types and constants for the decimal string to int64 unit.
// Used by ds2i_accum and decimal_string_to_int64_unit; depends on nothing.
`default_nettype none

package ds2i_pkg;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_INVALID   = 3'd2,
		ST_TOO_LARGE = 3'd3,
		ST_NO_DIGITS = 3'd4
	} status_t;

	localparam logic [7:0] CH_MINUS      = 8'h2D;
	localparam logic [7:0] CH_PLUS       = 8'h2B;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_ZERO       = 8'h30;
	localparam logic [7:0] CH_NINE       = 8'h39;

	localparam int MAG_W = 64;

	// Largest magnitude that can still take one more decimal digit in 64 bits.
	localparam logic [MAG_W-1:0] MAG_LIMIT       = 64'd1844674407370955161;
	localparam logic [3:0]       MAG_LIMIT_DIGIT = 4'd5;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       no_char;
		logic       last;
	} item_t;

	typedef struct packed {
		status_t          status;
		logic             negative;
		logic [MAG_W-1:0] magnitude;
	} result_t;

endpackage

`default_nettype wire

// ----- rtl/core/ds2i_accum.sv -----
// Parser state and per-byte update for the decimal string to int64 unit.
// Depends on ds2i_pkg.
`default_nettype none

module ds2i_accum (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             take,
	input  wire ds2i_pkg::item_t  item,
	output ds2i_pkg::result_t     res
);
	import ds2i_pkg::*;

	logic             at_start_q;
	logic             negative_q;
	logic             seen_digit_q;
	logic [MAG_W-1:0] magnitude_q;
	status_t          error_q;

	logic             at_start_n;
	logic             negative_n;
	logic             seen_digit_n;
	logic [MAG_W-1:0] magnitude_n;
	status_t          error_n;

	logic             consume;
	logic [3:0]       digit;
	logic             is_digit;
	logic             overflow;
	logic [MAG_W-1:0] mag_times_ten_plus;

	assign consume  = take && !item.no_char;
	assign digit    = item.char_byte[3:0];
	assign is_digit = (item.char_byte >= CH_ZERO) && (item.char_byte <= CH_NINE);
	assign overflow = (magnitude_q > MAG_LIMIT) ||
		((magnitude_q == MAG_LIMIT) && (digit > MAG_LIMIT_DIGIT));
	// Times ten as (m << 3) + (m << 1), plus the digit.
	assign mag_times_ten_plus = {magnitude_q[MAG_W-4:0], 3'b000} +
		{magnitude_q[MAG_W-2:0], 1'b0} + {{(MAG_W-4){1'b0}}, digit};

	always_comb begin
		at_start_n   = at_start_q;
		negative_n   = negative_q;
		seen_digit_n = seen_digit_q;
		magnitude_n  = magnitude_q;
		error_n      = error_q;
		if (consume) begin
			at_start_n = 1'b0;
			if (error_q == ST_OK) begin
				priority if (at_start_q &&
					(item.char_byte == CH_MINUS || item.char_byte == CH_PLUS)) begin
					negative_n = (item.char_byte == CH_MINUS);
				end else if (item.char_byte == CH_UNDERSCORE) begin
					negative_n = negative_q;
				end else if (!is_digit) begin
					error_n = ST_INVALID;
				end else begin
					seen_digit_n = 1'b1;
					if (overflow) begin
						error_n = ST_TOO_LARGE;
					end else begin
						magnitude_n = mag_times_ten_plus;
					end
				end
			end
		end
	end

	always_comb begin
		res.negative  = negative_n;
		res.magnitude = magnitude_n;
		priority if (error_n != ST_OK) begin
			res.status = error_n;
		end else if (at_start_n) begin
			res.status = ST_EMPTY;
		end else if (!seen_digit_n) begin
			res.status = ST_NO_DIGITS;
		end else if (magnitude_n[MAG_W-1]) begin
			res.status = ST_TOO_LARGE;
		end else begin
			res.status = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q   <= 1'b1;
			negative_q   <= 1'b0;
			seen_digit_q <= 1'b0;
			magnitude_q  <= '0;
			error_q      <= ST_OK;
		end else if (take && item.last) begin
			// The string is closed, so every entry returns to its reset value.
			at_start_q   <= 1'b1;
			negative_q   <= 1'b0;
			seen_digit_q <= 1'b0;
			magnitude_q  <= '0;
			error_q      <= ST_OK;
		end else begin
			at_start_q   <= at_start_n;
			negative_q   <= negative_n;
			seen_digit_q <= seen_digit_n;
			magnitude_q  <= magnitude_n;
			error_q      <= error_n;
		end
	end

	a_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take && item.last |=> at_start_q && !seen_digit_q && magnitude_q == '0 &&
			error_q == ST_OK)
		else $error("state not cleared after the closing transaction");

	a_error_latched: assert property (@(posedge clk) disable iff (!arst_n)
		error_q != ST_OK && !(take && item.last) |=> $stable(error_q) &&
			$stable(magnitude_q))
		else $error("latched error or magnitude changed");

	a_digit_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		seen_digit_q |-> !at_start_q)
		else $error("digit recorded while still at start of string");

	a_mag_needs_digit: assert property (@(posedge clk) disable iff (!arst_n)
		!seen_digit_q |-> magnitude_q == '0)
		else $error("nonzero magnitude without any digit");

endmodule

`default_nettype wire

// ----- rtl/core/decimal_string_to_int64_unit.sv -----
// An accepted byte is held in the stage-1 register and parsed as it leaves; a closing
// byte's result is registered as it leaves and offered on the result channel.
// Throughput: one byte per cycle; the bound is the 64-bit times-ten-plus-digit update
// of the magnitude register. The input stalls only while a closing byte waits behind
// a held result that the receiver is stalling.
// Reset: arst_n clears both valid flags and the parser state to the start of a string.
// Top level of the decimal string to int64 unit; depends on ds2i_pkg and ds2i_accum.
`default_nettype none

module decimal_string_to_int64_unit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                char_valid,
	output logic                     char_stall,
	input  wire logic [7:0]          char_byte,
	input  wire logic                no_char,
	input  wire logic                last,
	output logic                     result_valid,
	input  wire logic                result_stall,
	output logic signed [63:0]       value,
	output logic [2:0]               status
);
	import ds2i_pkg::*;

	logic       v_s1_q;
	item_t      item_s1;
	logic       s1_block;
	logic       take;
	result_t    res;

	logic             result_valid_q;
	status_t          status_q;
	logic             negative_q;
	logic [MAG_W-1:0] magnitude_q;

	// A closing byte cannot move on while the previous result still waits.
	assign s1_block   = v_s1_q && item_s1.last && result_valid_q && result_stall;
	assign take       = v_s1_q && !s1_block;
	assign char_stall = s1_block;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
		end else if (!s1_block) begin
			v_s1_q <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!s1_block && char_valid) begin
			item_s1.char_byte <= char_byte;
			item_s1.no_char   <= no_char;
			item_s1.last      <= last;
		end
	end

	ds2i_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (item_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (take && item_s1.last) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && item_s1.last) begin
			status_q    <= res.status;
			negative_q  <= res.negative;
			magnitude_q <= res.magnitude;
		end
	end

	assign result_valid = result_valid_q;
	assign status       = status_q;

	always_comb begin
		if (status_q != ST_OK) begin
			value = '0;
		end else if (negative_q) begin
			value = $signed(-magnitude_q);
		end else begin
			value = $signed(magnitude_q);
		end
	end

endmodule

`default_nettype wire
